>>> hdl/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Types and constants for the system-exclusive message classifier.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int unsigned FIELD_DEPTH = 7;

  localparam logic [3:0] COUNT_MAX        = 4'd15;
  localparam logic [3:0] POS_MODEL        = 4'd4;
  localparam logic [3:0] POS_TYPE         = 4'd5;
  localparam logic [3:0] POS_FIELD0       = 4'd6;

  localparam logic [3:0] LEN_SYSEX_MIN    = 4'd7;
  localparam logic [3:0] LEN_TEMPO        = 4'd7;
  localparam logic [3:0] LEN_PARAM_MIN    = 4'd14;
  localparam logic [3:0] LEN_FIRMWARE     = 4'd14;
  localparam logic [3:0] LEN_FRONTPANEL   = 4'd8;
  localparam logic [3:0] LEN_PRESET       = 4'd10;

  localparam logic [7:0] SOX              = 8'hF0;
  localparam logic [7:0] MFR_ID0          = 8'h00;
  localparam logic [7:0] MFR_ID1          = 8'h01;
  localparam logic [7:0] MFR_ID2          = 8'h74;
  localparam logic [7:0] CHK_MASK         = 8'h7F;
  localparam logic [7:0] EOX              = 8'hF7;

  localparam logic [7:0] TYPE_TEMPO       = 8'h10;
  localparam logic [7:0] TYPE_PARAM_VALUE = 8'h02;
  localparam logic [7:0] TYPE_FIRMWARE    = 8'h08;
  localparam logic [7:0] TYPE_FRONTPANEL  = 8'h21;
  localparam logic [7:0] TYPE_PRESET      = 8'h14;

  localparam logic [7:0] HEADER_BYTES [4] = '{SOX, MFR_ID0, MFR_ID1, MFR_ID2};

  typedef struct packed {
    logic        is_sysex;
    logic        is_tempo;
    logic        is_param_value;
    logic [14:0] block_id;
    logic [14:0] param_id;
    logic [21:0] param_value;
    logic        is_firmware_version;
    logic        is_frontpanel_change;
    logic        is_preset_number;
  } result_t;

endpackage

>>> hdl/sysex_message_classifier_unit.sv
// ----------------------------------------------------------------------------
// sysex_message_classifier_unit
// A last byte is held in the input register, and its result then in the result register.
// Throughput: one byte per cycle; the input register stalls only while it holds
// a last byte and the result register holds an untaken result.
// Reset: synchronous, active low; clears the message state, model_r and
// both valid flags.
// ----------------------------------------------------------------------------
module sysex_message_classifier_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_sysex,
  output logic        out_is_tempo,
  output logic        out_is_param_value,
  output logic [14:0] out_block_id,
  output logic [14:0] out_param_id,
  output logic [21:0] out_param_value,
  output logic        out_is_firmware_version,
  output logic        out_is_frontpanel_change,
  output logic        out_is_preset_number
);

  logic [7:0] model_r;

  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  logic [3:0] count_r;
  logic [3:0] count_nxt;
  logic       hdr_r;
  logic       hdr_nxt;
  logic [7:0] type_r;
  logic [7:0] type_nxt;
  logic [7:0] field_r   [smc_pkg::FIELD_DEPTH];
  logic [7:0] field_nxt [smc_pkg::FIELD_DEPTH];
  logic [7:0] xor_r;
  logic [7:0] xor_nxt;
  logic [7:0] prev_r;
  logic [7:0] prev_nxt;

  logic       hdr_upd;
  logic [7:0] type_upd;
  logic [7:0] field_upd [smc_pkg::FIELD_DEPTH];
  logic [3:0] len;

  smc_pkg::result_t res;
  smc_pkg::result_t out_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_load;

  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign out_load = s1_adv && s1_last_r;

  assign s1_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Fold the current byte into the message state.
  always_comb begin
    hdr_upd  = hdr_r;
    type_upd = type_r;
    for (int i = 0; i < smc_pkg::FIELD_DEPTH; i++) begin
      field_upd[i] = field_r[i];
      if (count_r == smc_pkg::POS_FIELD0 + 4'(i)) begin
        field_upd[i] = s1_byte_r;
      end
    end
    if (count_r < smc_pkg::POS_MODEL) begin
      if (s1_byte_r != smc_pkg::HEADER_BYTES[count_r[1:0]]) begin
        hdr_upd = 1'b0;
      end
    end else if (count_r == smc_pkg::POS_MODEL) begin
      if (s1_byte_r != model_r) begin
        hdr_upd = 1'b0;
      end
    end else if (count_r == smc_pkg::POS_TYPE) begin
      type_upd = s1_byte_r;
    end
    len = (count_r == smc_pkg::COUNT_MAX) ? smc_pkg::COUNT_MAX : count_r + 4'd1;
  end

  always_comb begin
    res.is_sysex = (len >= smc_pkg::LEN_SYSEX_MIN) && hdr_upd
                   && (prev_r == (xor_r & smc_pkg::CHK_MASK))
                   && (s1_byte_r == smc_pkg::EOX);
    res.is_tempo = (len == smc_pkg::LEN_TEMPO) && hdr_upd
                   && (type_upd == smc_pkg::TYPE_TEMPO)
                   && (field_upd[0] == smc_pkg::EOX);
    res.is_param_value = (len >= smc_pkg::LEN_PARAM_MIN)
                         && (type_upd == smc_pkg::TYPE_PARAM_VALUE);
    res.is_firmware_version  = (len == smc_pkg::LEN_FIRMWARE)
                               && (type_upd == smc_pkg::TYPE_FIRMWARE);
    res.is_frontpanel_change = (len == smc_pkg::LEN_FRONTPANEL)
                               && (type_upd == smc_pkg::TYPE_FRONTPANEL);
    res.is_preset_number     = (len == smc_pkg::LEN_PRESET)
                               && (type_upd == smc_pkg::TYPE_PRESET);
    res.block_id    = '0;
    res.param_id    = '0;
    res.param_value = '0;
    if (res.is_param_value) begin
      res.block_id    = {7'd0, field_upd[0]} | {field_upd[1], 7'd0};
      res.param_id    = {7'd0, field_upd[2]} | {field_upd[3], 7'd0};
      res.param_value = {14'd0, field_upd[4]} | {7'd0, field_upd[5], 7'd0}
                        | {field_upd[6], 14'd0};
    end
  end

  // Advance the message state; clear it after the last byte.
  always_comb begin
    count_nxt = count_r;
    hdr_nxt   = hdr_r;
    type_nxt  = type_r;
    xor_nxt   = xor_r;
    prev_nxt  = prev_r;
    for (int i = 0; i < smc_pkg::FIELD_DEPTH; i++) begin
      field_nxt[i] = field_r[i];
    end
    if (s1_adv) begin
      if (s1_last_r) begin
        count_nxt = '0;
        hdr_nxt   = 1'b1;
        type_nxt  = '0;
        xor_nxt   = '0;
        prev_nxt  = '0;
        for (int i = 0; i < smc_pkg::FIELD_DEPTH; i++) begin
          field_nxt[i] = '0;
        end
      end else begin
        count_nxt = len;
        hdr_nxt   = hdr_upd;
        type_nxt  = type_upd;
        xor_nxt   = xor_r ^ prev_r;
        prev_nxt  = s1_byte_r;
        for (int i = 0; i < smc_pkg::FIELD_DEPTH; i++) begin
          field_nxt[i] = field_upd[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      hdr_r       <= 1'b1;
      type_r      <= '0;
      xor_r       <= '0;
      prev_r      <= '0;
      for (int i = 0; i < smc_pkg::FIELD_DEPTH; i++) begin
        field_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        model_r <= cfg_wr_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      hdr_r       <= hdr_nxt;
      type_r      <= type_nxt;
      xor_r       <= xor_nxt;
      prev_r      <= prev_nxt;
      for (int i = 0; i < smc_pkg::FIELD_DEPTH; i++) begin
        field_r[i] <= field_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_is_sysex             = out_r.is_sysex;
  assign out_is_tempo             = out_r.is_tempo;
  assign out_is_param_value       = out_r.is_param_value;
  assign out_block_id             = out_r.block_id;
  assign out_param_id             = out_r.param_id;
  assign out_param_value          = out_r.param_value;
  assign out_is_firmware_version  = out_r.is_firmware_version;
  assign out_is_frontpanel_change = out_r.is_frontpanel_change;
  assign out_is_preset_number     = out_r.is_preset_number;

endmodule

>>> hdl/smc_checker.sv
// ----------------------------------------------------------------------------
// smc_checker
// Port-level checks for the system-exclusive message classifier.
// ----------------------------------------------------------------------------
module smc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_tempo,
  input logic        out_is_param_value,
  input logic [14:0] out_block_id,
  input logic [14:0] out_param_id,
  input logic [21:0] out_param_value,
  input logic        out_is_firmware_version,
  input logic        out_is_frontpanel_change,
  input logic        out_is_preset_number
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_param_value))
    else $error("result transaction dropped or changed while stalled");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_param_value |->
      out_block_id == 15'd0 && out_param_id == 15'd0 && out_param_value == 22'd0)
    else $error("parameter fields nonzero without parameter-value flag");

  a_one_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_is_tempo, out_is_param_value,
      out_is_firmware_version, out_is_frontpanel_change,
      out_is_preset_number}) <= 1)
    else $error("more than one message type flagged");

  a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte, 2))
    else $error("result without a last-byte transaction two cycles earlier");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sysex_message_classifier_unit smc_checker u_smc_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .in_valid                 (in_valid),
  .in_ready                 (in_ready),
  .in_last_byte             (in_last_byte),
  .out_valid                (out_valid),
  .out_ready                (out_ready),
  .out_is_tempo             (out_is_tempo),
  .out_is_param_value       (out_is_param_value),
  .out_block_id             (out_block_id),
  .out_param_id             (out_param_id),
  .out_param_value          (out_param_value),
  .out_is_firmware_version  (out_is_firmware_version),
  .out_is_frontpanel_change (out_is_frontpanel_change),
  .out_is_preset_number     (out_is_preset_number)
);

>>> tb/sv/smc_classifier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smc_classifier_checker
// Follows the byte stream and configuration writes of the classifier,
// predicts the classification of each message on its final byte, and
// compares every delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module smc_classifier_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_is_sysex,
  input  logic        out_is_tempo,
  input  logic        out_is_param_value,
  input  logic [14:0] out_block_id,
  input  logic [14:0] out_param_id,
  input  logic [21:0] out_param_value,
  input  logic        out_is_firmware_version,
  input  logic        out_is_frontpanel_change,
  input  logic        out_is_preset_number,
  output int          mismatch_count,
  output int          results_pending
);

  localparam int MAX_REPORTS = 10;

  logic [3:0]       rx_count;
  logic             hdr_ok;
  logic [7:0]       type_q;
  logic [7:0]       field_q [smc_pkg::FIELD_DEPTH];
  logic [7:0]       xor_acc;
  logic [7:0]       prev_q;
  logic [7:0]       model_q;
  smc_pkg::result_t class_q [$];

  task automatic clear_message();
    rx_count = '0;
    hdr_ok   = 1'b1;
    type_q   = '0;
    foreach (field_q[i]) field_q[i] = '0;
    xor_acc  = '0;
    prev_q   = '0;
  endtask

  function automatic string describe(input smc_pkg::result_t r);
    return $sformatf("sysex=%0d tempo=%0d pv=%0d blk=%h pid=%h val=%h fw=%0d fp=%0d pn=%0d",
                     r.is_sysex, r.is_tempo, r.is_param_value, r.block_id, r.param_id,
                     r.param_value, r.is_firmware_version, r.is_frontpanel_change,
                     r.is_preset_number);
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    logic [3:0]       len;
    logic [7:0]       chk;
    smc_pkg::result_t r;
    if (rx_count < smc_pkg::POS_MODEL) begin
      if (b != smc_pkg::HEADER_BYTES[rx_count[1:0]]) hdr_ok = 1'b0;
    end else if (rx_count == smc_pkg::POS_MODEL) begin
      if (b != model_q) hdr_ok = 1'b0;
    end else if (rx_count == smc_pkg::POS_TYPE) begin
      type_q = b;
    end else if (rx_count < smc_pkg::POS_FIELD0 + smc_pkg::FIELD_DEPTH) begin
      field_q[3'(rx_count - smc_pkg::POS_FIELD0)] = b;
    end
    if (!last) begin
      xor_acc = xor_acc ^ prev_q;
      prev_q  = b;
      if (rx_count != smc_pkg::COUNT_MAX) rx_count = rx_count + 4'd1;
    end else begin
      len = (rx_count != smc_pkg::COUNT_MAX) ? rx_count + 4'd1 : smc_pkg::COUNT_MAX;
      chk = xor_acc & smc_pkg::CHK_MASK;
      r = '0;
      r.is_sysex = (len >= smc_pkg::LEN_SYSEX_MIN) && hdr_ok && (prev_q == chk)
                   && (b == smc_pkg::EOX);
      r.is_tempo = (len == smc_pkg::LEN_TEMPO) && hdr_ok
                   && (type_q == smc_pkg::TYPE_TEMPO) && (field_q[0] == smc_pkg::EOX);
      r.is_param_value       = (len >= smc_pkg::LEN_PARAM_MIN)
                               && (type_q == smc_pkg::TYPE_PARAM_VALUE);
      r.is_firmware_version  = (len == smc_pkg::LEN_FIRMWARE)
                               && (type_q == smc_pkg::TYPE_FIRMWARE);
      r.is_frontpanel_change = (len == smc_pkg::LEN_FRONTPANEL)
                               && (type_q == smc_pkg::TYPE_FRONTPANEL);
      r.is_preset_number     = (len == smc_pkg::LEN_PRESET)
                               && (type_q == smc_pkg::TYPE_PRESET);
      if (r.is_param_value) begin
        r.block_id    = 15'(field_q[0]) | (15'(field_q[1]) << 7);
        r.param_id    = 15'(field_q[2]) | (15'(field_q[3]) << 7);
        r.param_value = 22'(field_q[4]) | (22'(field_q[5]) << 7) | (22'(field_q[6]) << 14);
      end
      class_q.push_back(r);
      clear_message();
    end
  endtask

  task automatic check_result();
    smc_pkg::result_t act;
    smc_pkg::result_t exp_r;
    act = {out_is_sysex, out_is_tempo, out_is_param_value, out_block_id, out_param_id,
           out_param_value, out_is_firmware_version, out_is_frontpanel_change,
           out_is_preset_number};
    if (class_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("checker: unexpected result %s", describe(act));
    end else begin
      exp_r = class_q.pop_front();
      if (act !== exp_r) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("checker: result mismatch at %0t", $realtime);
          $display("  expected %s", describe(exp_r));
          $display("  actual   %s", describe(act));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_message();
      model_q = '0;
      class_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) absorb_byte(in_data_byte, in_last_byte);
      if (cfg_wr_en) model_q = cfg_wr_data;
    end
    results_pending = class_q.size();
  end

endmodule

>>> tb/sv/tb_sysex_message_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sysex_message_classifier_unit
// Drives system-exclusive messages into the classifier: a directed set of
// message types and corner cases, then random well-formed, corrupted and
// noise messages under several model numbers, with bursty input and a
// stalling result consumer. The checker beside the block scores results.
// ----------------------------------------------------------------------------
module tb_sysex_message_classifier_unit;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_BYTES  = 110;
  localparam int DRAIN_CYCLES = 6;

  typedef enum int {
    MSG_TEMPO, MSG_PARAM, MSG_FIRMWARE, MSG_FRONTPANEL, MSG_PRESET, MSG_OTHER, MSG_NOISE
  } msg_kind_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE, RX_PERIODIC} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_is_sysex;
  logic        out_is_tempo;
  logic        out_is_param_value;
  logic [14:0] out_block_id;
  logic [14:0] out_param_id;
  logic [21:0] out_param_value;
  logic        out_is_firmware_version;
  logic        out_is_frontpanel_change;
  logic        out_is_preset_number;
  int          mismatch_count;
  int          results_pending;

  logic [7:0]  msg_q [$];
  logic [7:0]  model_now;
  int          burst_left;
  int          cycle_count = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int          rx_phase = 0;

  sysex_message_classifier_unit dut (.*);

  smc_classifier_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= rx_phase[2];
    endcase
    rx_phase++;
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_message();
    foreach (msg_q[i]) push_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  function automatic logic [7:0] field_byte();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 127));
  endfunction

  task automatic frame_message(input logic [7:0] mtype, input int payload_len,
                               input bit fixed, input logic [7:0] fill);
    logic [7:0] chk;
    msg_q = {smc_pkg::SOX, smc_pkg::MFR_ID0, smc_pkg::MFR_ID1, smc_pkg::MFR_ID2,
             model_now, mtype};
    repeat (payload_len) msg_q.push_back(fixed ? fill : field_byte());
    chk = '0;
    foreach (msg_q[i]) chk = chk ^ msg_q[i];
    msg_q.push_back(chk & smc_pkg::CHK_MASK);
    msg_q.push_back(smc_pkg::EOX);
  endtask

  task automatic build_message(input msg_kind_t kind);
    int len;
    case (kind)
      MSG_TEMPO:      msg_q = {smc_pkg::SOX, smc_pkg::MFR_ID0, smc_pkg::MFR_ID1,
                               smc_pkg::MFR_ID2, model_now, smc_pkg::TYPE_TEMPO,
                               smc_pkg::EOX};
      MSG_PARAM:      frame_message(smc_pkg::TYPE_PARAM_VALUE, $urandom_range(6, 12),
                                    1'b0, '0);
      MSG_FIRMWARE:   frame_message(smc_pkg::TYPE_FIRMWARE, 6, 1'b0, '0);
      MSG_FRONTPANEL: frame_message(smc_pkg::TYPE_FRONTPANEL, 0, 1'b0, '0);
      MSG_PRESET:     frame_message(smc_pkg::TYPE_PRESET, 2, 1'b0, '0);
      MSG_OTHER:      frame_message(8'($urandom_range(0, 255)), $urandom_range(0, 10),
                                    1'b0, '0);
      default: begin
        len = $urandom_range(1, 20);
        msg_q.delete();
        if ($urandom_range(0, 1) == 1) msg_q.push_back(smc_pkg::SOX);
        while (msg_q.size() < len) msg_q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_model(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    model_now    = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(input int byte_budget);
    int sent;
    int pick;
    int idx;
    sent = 0;
    while (sent < byte_budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        build_message(MSG_NOISE);
      end else begin
        build_message(msg_kind_t'($urandom_range(0, 5)));
        if (pick < 30) begin
          idx = $urandom_range(0, msg_q.size() - 1);
          msg_q[idx] = msg_q[idx] ^ 8'($urandom_range(1, 255));
        end
      end
      sent += msg_q.size();
      send_message();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    model_now    = '0;
    burst_left   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_model(8'($urandom_range(0, 255)));

    build_message(MSG_TEMPO);
    send_message();
    frame_message(smc_pkg::TYPE_PARAM_VALUE, 7, 1'b1, 8'hFF);
    send_message();
    frame_message(smc_pkg::TYPE_PARAM_VALUE, 6, 1'b1, 8'h00);
    send_message();
    frame_message(smc_pkg::TYPE_PARAM_VALUE, 12, 1'b1, 8'h7F);
    send_message();
    build_message(MSG_FIRMWARE);
    send_message();
    frame_message(smc_pkg::TYPE_FIRMWARE, 7, 1'b0, '0);
    send_message();
    build_message(MSG_FRONTPANEL);
    send_message();
    build_message(MSG_PRESET);
    send_message();
    msg_q = {8'hFF};
    send_message();
    msg_q = {smc_pkg::SOX, smc_pkg::MFR_ID0, smc_pkg::MFR_ID1, smc_pkg::MFR_ID2,
             model_now, smc_pkg::TYPE_PARAM_VALUE};
    send_message();
    frame_message(smc_pkg::TYPE_PARAM_VALUE, 7, 1'b0, '0);
    msg_q[1] = 8'h7F;
    send_message();
    build_message(MSG_PRESET);
    msg_q[msg_q.size() - 2] = msg_q[msg_q.size() - 2] ^ 8'h01;
    send_message();
    build_message(MSG_FRONTPANEL);
    msg_q[msg_q.size() - 1] = smc_pkg::SOX;
    send_message();
    build_message(MSG_TEMPO);
    msg_q[smc_pkg::POS_MODEL] = msg_q[smc_pkg::POS_MODEL] ^ 8'h80;
    send_message();

    wait_idle();
    write_model(8'h00);
    run_random(PHASE_BYTES);
    wait_idle();
    write_model(8'hFF);
    run_random(PHASE_BYTES);
    wait_idle();
    write_model(8'($urandom_range(0, 255)));
    run_random(PHASE_BYTES);
    wait_idle();
    write_model(8'h7F);
    run_random(PHASE_BYTES);
    wait_idle();

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sysex_message_classifier_unit.f
hdl/smc_pkg.sv
hdl/sysex_message_classifier_unit.sv
hdl/smc_checker.sv
tb/sv/smc_classifier_checker.sv
tb/sv/tb_sysex_message_classifier_unit.sv
